>>> hdl/hvt_pkg.sv
// shared types and constants for the homogeneous vertex transform
package hvt_pkg;

  localparam int FX_W      = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int NUM_ELEMS = 16;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic do_div;
    logic flag;
    fx_t  x;
    fx_t  y;
    fx_t  z;
    fx_t  w;
  } side_t;

endpackage

>>> hdl/hvt_row_mac.sv
// one matrix row: four products, exact sum, floor shift and saturation
module hvt_row_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            en,
  input  hvt_pkg::fx_t    v   [4],
  input  hvt_pkg::fx_t    m   [4],
  output hvt_pkg::fx_t    res,
  output logic            ovf
);
  import hvt_pkg::*;

  logic signed [63:0] prod_r [4];
  logic signed [65:0] sum_r;
  logic signed [65:0] sum_nxt;
  logic signed [65:0] sh;
  fx_t                res_r;
  fx_t                res_nxt;
  logic               ovf_r;
  logic               ovf_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c] <= 64'(v[c]) * 64'(m[c]);
      end
      sum_r <= sum_nxt;
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    sum_nxt = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2]) + 66'(prod_r[3]);
    sh      = sum_r >>> FRAC_BITS;
    ovf_nxt = 1'b0;
    res_nxt = sh[FX_W-1:0];
    if (sh > 66'(FX_MAX)) begin
      res_nxt = FX_MAX;
      ovf_nxt = 1'b1;
    end else if (sh < 66'(FX_MIN)) begin
      res_nxt = FX_MIN;
      ovf_nxt = 1'b1;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

>>> hdl/hvt_div_lane.sv
// pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage
module hvt_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         en,
  input  hvt_pkg::fx_t num,
  input  hvt_pkg::fx_t den,
  output hvt_pkg::fx_t quo,
  output logic         ovf
);
  import hvt_pkg::*;

  localparam int NB = FX_W + FRAC_BITS;

  logic [FX_W-1:0] a_r   [NB+1];
  logic [NB-1:0]   q_r   [NB+1];
  logic [FX_W-1:0] d_r   [NB+1];
  logic            neg_r [NB+1];
  logic [FX_W-1:0] num_mag;
  logic [FX_W-1:0] den_mag;
  fx_t             quo_r;
  fx_t             quo_nxt;
  logic            ovf_r;
  logic            ovf_nxt;
  logic [NB-1:0]   qf;
  logic [NB-1:0]   lim;

  assign num_mag = num[FX_W-1] ? FX_W'(-num) : FX_W'(num);
  assign den_mag = den[FX_W-1] ? FX_W'(-den) : FX_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= '0;
      q_r[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
      d_r[0]   <= den_mag;
      neg_r[0] <= num[FX_W-1] ^ den[FX_W-1];
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [FX_W:0]   a_sh;
    logic            ge;
    logic [FX_W:0]   a_sub;
    assign a_sh  = {a_r[k], q_r[k][NB-1]};
    assign ge    = a_sh >= {1'b0, d_r[k]};
    assign a_sub = a_sh - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k+1]   <= ge ? a_sub[FX_W-1:0] : a_sh[FX_W-1:0];
        q_r[k+1]   <= {q_r[k][NB-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_comb begin
    qf  = q_r[NB];
    lim = neg_r[NB] ? NB'(33'h1_0000_0000 >> 1) : NB'(32'h7fff_ffff);
    ovf_nxt = qf > lim;
    if (ovf_nxt) begin
      quo_nxt = neg_r[NB] ? FX_MIN : FX_MAX;
    end else begin
      quo_nxt = neg_r[NB] ? fx_t'(-qf[FX_W-1:0]) : fx_t'(qf[FX_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule

>>> hdl/homogeneous_vertex_transform.sv
// top level: 4x4 fixed-point matrix transform with optional perspective divide
//
// input channel: in_valid/in_stall with in_kind, in_x, in_y, in_z, in_w
// (signed fixed point, FRAC_BITS fraction bits). in_kind 1 selects the
// point transform, which divides x, y and z by w unless w is 0 or 1.0.
// result channel: out_valid/out_stall with out_x..out_w and out_saturated.
// configuration: cfg_we writes cfg_data into matrix pair cfg_index (0..7),
// element 2i in the low half and 2i+1 in the high half; other indexes
// are ignored. write only while no item is in flight.
// the pipeline runs through the input registers, the multiply and sum
// stages, one divider stage per quotient bit and the output register.
// one item per cycle unless the output stalls; every item passes the divider.
// reset clears all valid bits and loads the identity matrix.
// a stalled output freezes the whole pipeline and raises in_stall;
// nothing is lost or repeated.
module homogeneous_vertex_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  hvt_pkg::fx_t                    in_x,
  input  hvt_pkg::fx_t                    in_y,
  input  hvt_pkg::fx_t                    in_z,
  input  hvt_pkg::fx_t                    in_w,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hvt_pkg::fx_t                    out_x,
  output hvt_pkg::fx_t                    out_y,
  output hvt_pkg::fx_t                    out_z,
  output hvt_pkg::fx_t                    out_w,
  output logic                            out_saturated,
  input  logic                            cfg_we,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvt_pkg::CFG_W-1:0]       cfg_data
);
  import hvt_pkg::*;

  localparam int  NB  = FX_W + FRAC_BITS;
  localparam int  LAT = NB + 7;
  localparam fx_t ONE = fx_t'(64'd1 << FRAC_BITS);

  logic        en;
  logic [LAT-1:0] vld_r;
  fx_t         mat_r [NUM_ELEMS];
  fx_t         v_r   [4];
  logic        kind_r [4];
  fx_t         res   [4];
  logic        rovf  [4];
  fx_t         mrow  [4][4];
  side_t       side_in;
  side_t       side_r [NB+2];
  side_t       so;
  fx_t         qx, qy, qz;
  logic        ox, oy, oz;
  fx_t         out_x_r, out_y_r, out_z_r, out_w_r;
  logic        out_sat_r;
  logic        out_div_r;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mat_r[{cfg_index[2:0], 1'b0}] <= cfg_data[FX_W-1:0];
      mat_r[{cfg_index[2:0], 1'b1}] <= cfg_data[CFG_W-1:FX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= in_x;
      v_r[1]    <= in_y;
      v_r[2]    <= in_z;
      v_r[3]    <= in_w;
      kind_r[0] <= in_kind;
      for (int i = 1; i < 4; i++) begin
        kind_r[i] <= kind_r[i-1];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mrow[r][c] = mat_r[r + 4*c];
    end
    hvt_row_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clk (clk),
      .en  (en),
      .v   (v_r),
      .m   (mrow[r]),
      .res (res[r]),
      .ovf (rovf[r])
    );
  end

  always_comb begin
    side_in.do_div = kind_r[3] && res[3] != '0 && res[3] != ONE;
    side_in.flag   = rovf[0] | rovf[1] | rovf[2] | rovf[3];
    side_in.x      = res[0];
    side_in.y      = res[1];
    side_in.z      = res[2];
    side_in.w      = res[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NB+2; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  hvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .num(res[0]), .den(res[3]), .quo(qx), .ovf(ox)
  );
  hvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .num(res[1]), .den(res[3]), .quo(qy), .ovf(oy)
  );
  hvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .en(en), .num(res[2]), .den(res[3]), .quo(qz), .ovf(oz)
  );

  assign so = side_r[NB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_div_r <= so.do_div;
      if (so.do_div) begin
        out_x_r   <= qx;
        out_y_r   <= qy;
        out_z_r   <= qz;
        out_w_r   <= ONE;
        out_sat_r <= so.flag | ox | oy | oz;
      end else begin
        out_x_r   <= so.x;
        out_y_r   <= so.y;
        out_z_r   <= so.z;
        out_w_r   <= so.w;
        out_sat_r <= so.flag;
      end
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_w         = out_w_r;
  assign out_saturated = out_sat_r;

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_w))
    else $error("blocked result changed");

  a_div_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_r |-> out_w == ONE)
    else $error("divided item without unit w");

endmodule

>>> verif/homogeneous_vertex_transform_tb.sv
// self-checking testbench for the homogeneous vertex transform with a scoreboard class
module homogeneous_vertex_transform_tb;
  import hvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC = 16;
  localparam fx_t ONE_FX = fx_t'(1) <<< FRAC;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_CYCLES = 80;

  typedef logic signed [67:0] wide_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
    fx_t w;
    logic sat;
  } vertex_t;

  class vertex_scoreboard;
    fx_t     mat[NUM_ELEMS];
    vertex_t pending[$];
    int      errors;
    int      n_in;
    int      n_out;
    int      n_div;
    int      n_sat;

    function new();
      for (int i = 0; i < NUM_ELEMS; i++) mat[i] = '0;
      mat[0] = ONE_FX;
      mat[5] = ONE_FX;
      mat[10] = ONE_FX;
      mat[15] = ONE_FX;
    endfunction

    function void set_pair(int idx, logic [CFG_W-1:0] data);
      if (idx < NUM_REGS) begin
        mat[2*idx] = data[31:0];
        mat[2*idx+1] = data[63:32];
      end
    endfunction

    function fx_t clip(wide_t v, inout logic f);
      if (v > wide_t'(FX_MAX)) begin
        f = 1'b1;
        return FX_MAX;
      end
      if (v < wide_t'(FX_MIN)) begin
        f = 1'b1;
        return FX_MIN;
      end
      return v[31:0];
    endfunction

    function void note(logic kind, fx_t x, fx_t y, fx_t z, fx_t w);
      fx_t     v[4];
      fx_t     res[4];
      wide_t   acc;
      wide_t   a;
      wide_t   b;
      logic    f;
      vertex_t e;
      v[0] = x; v[1] = y; v[2] = z; v[3] = w;
      f = 1'b0;
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          a = wide_t'(v[c]);
          b = wide_t'(mat[r + 4*c]);
          acc = acc + a * b;
        end
        res[r] = clip(acc >>> FRAC, f);
      end
      if (kind && res[3] != 0 && res[3] != ONE_FX) begin
        b = wide_t'(res[3]);
        for (int r = 0; r < 3; r++) begin
          a = wide_t'(res[r]);
          a = a <<< FRAC;
          res[r] = clip(a / b, f);
        end
        res[3] = ONE_FX;
        n_div++;
      end
      e.x = res[0]; e.y = res[1]; e.z = res[2]; e.w = res[3]; e.sat = f;
      pending.push_back(e);
      n_in++;
    endfunction

    function void check(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h w=%h sat=%b", $time,
                 got.x, got.y, got.z, got.w, got.sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_out++;
      if (got.sat) n_sat++;
      if (got.x !== e.x) begin
        $display("%0t: x expected %h actual %h", $time, e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: y expected %h actual %h", $time, e.y, got.y); errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t: z expected %h actual %h", $time, e.z, got.z); errors++;
      end
      if (got.w !== e.w) begin
        $display("%0t: w expected %h actual %h", $time, e.w, got.w); errors++;
      end
      if (got.sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  fx_t  in_x = '0;
  fx_t  in_y = '0;
  fx_t  in_z = '0;
  fx_t  in_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fx_t  out_x;
  fx_t  out_y;
  fx_t  out_z;
  fx_t  out_w;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  vertex_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  long_hold_done = 1'b0;
  int  hold_left = 0;

  always #4 clk = ~clk;

  homogeneous_vertex_transform #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("homogeneous_vertex_transform: mismatch");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note(in_kind, in_x, in_y, in_z, in_w);
      if (out_valid && !out_stall)
        sb.check({out_x, out_y, out_z, out_w, out_saturated});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // receiver side, with one long hold-off so the pipeline backs up
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (!long_hold_done && sb.n_in >= 150) begin
        long_hold_done = 1'b1;
        hold_left = 400;
        out_stall = 1'b1;
      end else begin
        hold_left = pick_gap();
        out_stall = (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  task automatic send_vertex(logic kind, fx_t x, fx_t y, fx_t z, fx_t w);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_x = x; in_y = y; in_z = z; in_w = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pair(int idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_data = data;
    sb.set_pair(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic fx_t small_fx(int mag);
    return fx_t'($signed($urandom_range(0, 2*mag)) - mag);
  endfunction

  function automatic fx_t pick_elem(int mode);
    case (mode)
      0: return '0;
      1: return small_fx(1 << 18);
      2: return $urandom;
      3: return FX_MAX;
      4: return FX_MIN;
      default: return '0;
    endcase
  endfunction

  // mode 0 identity, 1 small random, 2 full random, 3 all max, 4 all min, 5 zero
  task automatic load_matrix(int mode);
    fx_t lo;
    fx_t hi;
    for (int i = 0; i < NUM_REGS; i++) begin
      lo = pick_elem(mode);
      hi = pick_elem(mode);
      if (mode == 0) begin
        lo = (2*i) % 5 == 0 ? ONE_FX : '0;
        hi = (2*i + 1) % 5 == 0 ? ONE_FX : '0;
      end
      write_pair(i, {hi, lo});
    end
    write_pair($urandom_range(NUM_REGS, 15), {$urandom, $urandom});
  endtask

  function automatic fx_t pick_val();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return small_fx(1 << 20);
    if (r < 9) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return ONE_FX;
        2: return -ONE_FX;
        3: return FX_MAX;
        default: return FX_MIN;
      endcase
    end
    return small_fx(4);
  endfunction

  int phase_mode[8] = '{1, 2, 0, 1, 3, 4, 5, 1};
  int phase_len[8]  = '{400, 250, 200, 300, 60, 60, 30, 550};

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identity matrix from reset: divide cases and extremes
    send_vertex(1'b0, FX_MAX, FX_MIN, FX_MAX, FX_MIN);
    send_vertex(1'b1, FX_MAX, FX_MIN, FX_MAX, FX_MIN);
    send_vertex(1'b1, ONE_FX, 2*ONE_FX, 3*ONE_FX, '0);
    send_vertex(1'b1, ONE_FX, 2*ONE_FX, 3*ONE_FX, ONE_FX);
    send_vertex(1'b1, ONE_FX, -2*ONE_FX, 3*ONE_FX, 2*ONE_FX);
    send_vertex(1'b1, 5*ONE_FX, 7*ONE_FX, -9*ONE_FX, -ONE_FX);
    send_vertex(1'b1, FX_MAX, FX_MIN, 12345, ONE_FX >>> 1);
    send_vertex(1'b1, FX_MIN, FX_MAX, -1, -1);
    send_vertex(1'b1, FX_MIN, 3, 7, 1);
    send_vertex(1'b1, 100, -100, 77, FX_MAX);
    send_vertex(1'b1, 100, -100, 77, FX_MIN);
    send_vertex(1'b0, '0, '0, '0, '0);
    send_vertex(1'b1, '0, '0, '0, '0);
    send_vertex(1'b0, -1, -1, -1, -1);
    drain();

    // all-max matrix: row overflow, divide by a clipped w
    load_matrix(3);
    send_vertex(1'b0, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_vertex(1'b1, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    send_vertex(1'b1, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    send_vertex(1'b1, 1, 0, 0, 0);
    send_vertex(1'b1, ONE_FX, -ONE_FX, 3, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      calm = (p == 2);
      load_matrix(phase_mode[p]);
      for (int n = 0; n < phase_len[p]; n++)
        send_vertex(1'($urandom_range(0, 1)), pick_val(), pick_val(), pick_val(),
                    pick_val());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d vertices, %0d results, %0d perspective divides, %0d saturated",
             sb.n_in, sb.n_out, sb.n_div, sb.n_sat);
    $display("matrices: identity, small and full random, all max, all min, zero");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("homogeneous_vertex_transform: match");
    end else begin
      $display("homogeneous_vertex_transform: mismatch");
    end
    $finish;
  end

endmodule
